// ----- design/japc_pkg.sv -----
package japc_pkg;

  // Field and register widths.
  localparam int JSEL_W  = 2;
  localparam int ANG_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int RATE_W  = 15;
  localparam int FRAC_W  = 9;
  localparam int SUM_W   = 32;
  localparam int DIFF_W  = ANG_W + 1;
  localparam int ACC_W   = 50;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int LIM_W   = 16;

  // Default joint count.
  localparam int JOINTS_DEF = 4;

  // Register reset values.
  localparam logic [GAIN_W-1:0] KP_RST       = 16'd1408;
  localparam logic [GAIN_W-1:0] KI_RST       = 16'd0;
  localparam logic [GAIN_W-1:0] KD_RST       = 16'd192;
  localparam logic [RATE_W-1:0] MAX_RATE_RST = 15'd9865;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_KP       = 2'd0,
    REG_KI       = 2'd1,
    REG_KD       = 2'd2,
    REG_MAX_RATE = 2'd3
  } cfg_reg_t;

  // Result of the read-modify-write stage, handed to the multiply stage.
  typedef struct packed {
    logic                      valid;
    logic [JSEL_W-1:0]         joint;
    logic signed [ANG_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SUM_W-1:0]   sum;
    logic [FRAC_W-1:0]         frac;
  } rmw_res_t;

endpackage

// ----- design/japc_rmw.sv -----
module japc_rmw #(
  parameter int JOINTS = japc_pkg::JOINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [japc_pkg::JSEL_W-1:0]         in_joint,
  input  logic signed [japc_pkg::ANG_W-1:0]   in_target,
  input  logic signed [japc_pkg::ANG_W-1:0]   in_measured,
  input  logic [japc_pkg::FRAC_W-1:0]         in_frac,
  input  logic                                next_load,
  output japc_pkg::rmw_res_t                  res
);
  import japc_pkg::*;

  localparam int JIW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int WORD_W = SUM_W + ANG_W;

  // Per-joint state memory: {error_sum, previous_error}.
  logic [WORD_W-1:0] mem [JOINTS];
  logic [JOINTS-1:0] vld_r;

  logic                     v1_r;
  logic [JSEL_W-1:0]        joint_r;
  logic [JIW-1:0]           idx_r;
  logic signed [ANG_W-1:0]  target_r;
  logic signed [ANG_W-1:0]  measured_r;
  logic [FRAC_W-1:0]        frac_r;
  logic [WORD_W-1:0]        rd_q_r;
  logic                     rd_vld_r;
  logic                     fwd_hit_r;
  logic [WORD_W-1:0]        fwd_q_r;

  logic [JIW-1:0]           in_idx;
  logic                     load;
  logic                     wr_en;
  logic [WORD_W-1:0]        old_word;
  logic signed [ANG_W-1:0]  prev_err;
  logic signed [SUM_W-1:0]  old_sum;
  logic signed [DIFF_W-1:0] raw_err;
  logic signed [ANG_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SUM_W:0]    raw_sum;
  logic signed [SUM_W-1:0]  sum;

  // Joints beyond the count wrap onto the stored entries.
  always_comb begin
    in_idx = '0;
    for (int v = 0; v < (1 << JSEL_W); v++) begin
      if (in_joint == JSEL_W'(v)) begin
        in_idx = JIW'(v % JOINTS);
      end
    end
  end

  assign load     = !v1_r || next_load;
  assign in_ready = load;
  assign wr_en    = v1_r && next_load;

  // Read port, write-back and valid bits for the state memory.
  always_ff @(posedge clk) begin
    if (load) begin
      rd_q_r <= mem[in_idx];
    end
    if (wr_en) begin
      mem[idx_r] <= {sum, err};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // Stage register; forwards a write-back to the same joint issued at the read edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (load) begin
      v1_r <= in_valid;
    end
    if (load) begin
      joint_r    <= in_joint;
      idx_r      <= in_idx;
      target_r   <= in_target;
      measured_r <= in_measured;
      frac_r     <= in_frac;
      rd_vld_r   <= vld_r[in_idx];
      fwd_hit_r  <= wr_en && (idx_r == in_idx);
      fwd_q_r    <= {sum, err};
    end
  end

  // Entries never written read as zero.
  always_comb begin
    if (fwd_hit_r) begin
      old_word = fwd_q_r;
    end else if (rd_vld_r) begin
      old_word = rd_q_r;
    end else begin
      old_word = '0;
    end
  end

  assign prev_err = old_word[ANG_W-1:0];
  assign old_sum  = old_word[WORD_W-1:ANG_W];

  // Saturated error, exact difference and saturated sum.
  always_comb begin
    raw_err = DIFF_W'(target_r) - DIFF_W'(measured_r);
    if (raw_err[DIFF_W-1] != raw_err[DIFF_W-2]) begin
      err = raw_err[DIFF_W-1] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
    end else begin
      err = raw_err[ANG_W-1:0];
    end
    diff    = DIFF_W'(err) - DIFF_W'(prev_err);
    raw_sum = (SUM_W+1)'(old_sum) + (SUM_W+1)'(err);
    if (raw_sum[SUM_W] != raw_sum[SUM_W-1]) begin
      sum = raw_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum = raw_sum[SUM_W-1:0];
    end
  end

  assign res.valid = v1_r;
  assign res.joint = joint_r;
  assign res.err   = err;
  assign res.diff  = diff;
  assign res.sum   = sum;
  assign res.frac  = frac_r;

endmodule

// ----- design/joint_angle_pid_clamped.sv -----
// Stages: read-modify-write, multiply, accumulate, output. Throughput: one
// request per cycle while out_tready is high; the per-joint state is read
// from a small memory at the accepting edge and written back when the request
// moves on, with forwarding of a back-to-back update to the same joint.
// Reset (rst_n low, synchronous): gains and speed limit return to defaults,
// the pipeline empties and all joint state reads as zero.
module joint_angle_pid_clamped #(
  parameter int JOINTS = japc_pkg::JOINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [1:0] joint_index, [17:2] target_angle, [33:18] measured_angle,
  // [42:34] speed_fraction, [47:43] zero
  input  logic [47:0]                   in_tdata,
  // Result channel.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] out_joint, [17:2] speed_command, [23:18] zero
  output logic [23:0]                   out_tdata,
  // [0] limited
  output logic                          out_tuser,
  // Configuration port.
  input  logic                          cfg_wr_en,
  input  japc_pkg::cfg_reg_t            cfg_index,
  input  logic [japc_pkg::CFG_W-1:0]    cfg_wdata
);
  import japc_pkg::*;

  logic [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [RATE_W-1:0] max_rate_r;

  rmw_res_t          s1;
  logic              en2, en3, en_out;

  logic                      v2_r;
  logic [JSEL_W-1:0]         joint2_r;
  logic signed [32:0]        pkp_r;
  logic signed [48:0]        pki_r;
  logic signed [33:0]        pkd_r;
  logic [LIM_W-1:0]          lim2_r;
  logic [LIM_W-1:0]          lim_nxt;

  logic                      v3_r;
  logic [JSEL_W-1:0]         joint3_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [LIM_W-1:0]          lim3_r;

  logic                      out_valid_r;
  logic [JSEL_W-1:0]         out_joint_r;
  logic signed [ANG_W-1:0]   out_speed_r;
  logic                      out_lim_r;

  logic                      neg;
  logic [ACC_W-1:0]          rnd;
  logic [ACC_W-9:0]          mag;
  logic [LIM_W-1:0]          m1;
  logic [LIM_W-1:0]          m2;
  logic                      hit;
  logic signed [ANG_W-1:0]   speed_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= KP_RST;
      ki_r       <= KI_RST;
      kd_r       <= KD_RST;
      max_rate_r <= MAX_RATE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KP:       kp_r       <= cfg_wdata[GAIN_W-1:0];
        REG_KI:       ki_r       <= cfg_wdata[GAIN_W-1:0];
        REG_KD:       kd_r       <= cfg_wdata[GAIN_W-1:0];
        REG_MAX_RATE: max_rate_r <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage loads when it is empty or its successor loads.
  assign en_out = !out_valid_r || out_tready;
  assign en3    = !v3_r || en_out;
  assign en2    = !v2_r || en3;

  // State read-modify-write stage.
  japc_rmw #(.JOINTS(JOINTS)) u_rmw (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_joint    (in_tdata[1:0]),
    .in_target   (in_tdata[17:2]),
    .in_measured (in_tdata[33:18]),
    .in_frac     (in_tdata[42:34]),
    .next_load   (en2),
    .res         (s1)
  );

  // Multiply stage: gain products and the fractional speed limit.
  assign lim_nxt = LIM_W'((24'(max_rate_r) * 24'(s1.frac)) >> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= s1.valid;
    end
    if (en2) begin
      joint2_r <= s1.joint;
      pkp_r    <= 33'($signed({1'b0, kp_r})) * 33'(s1.err);
      pki_r    <= 49'($signed({1'b0, ki_r})) * 49'(s1.sum);
      pkd_r    <= 34'($signed({1'b0, kd_r})) * 34'(s1.diff);
      lim2_r   <= lim_nxt;
    end
  end

  // Accumulate stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      joint3_r <= joint2_r;
      acc_r    <= ACC_W'(pkp_r) + ACC_W'(pki_r) + ACC_W'(pkd_r);
      lim3_r   <= lim2_r;
    end
  end

  // Round the magnitude half away from zero, then apply both limits.
  always_comb begin
    neg = acc_r[ACC_W-1];
    rnd = neg ? (~acc_r + ACC_W'(129)) : (acc_r + ACC_W'(128));
    mag = rnd[ACC_W-1:8];
    hit = 1'b0;
    if (mag > (ACC_W-8)'(lim3_r)) begin
      m1  = lim3_r;
      hit = 1'b1;
    end else begin
      m1 = mag[LIM_W-1:0];
    end
    if (m1 > LIM_W'(max_rate_r)) begin
      m2  = LIM_W'(max_rate_r);
      hit = 1'b1;
    end else begin
      m2 = m1;
    end
    speed_nxt = neg ? (ANG_W'(0) - m2) : m2;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v3_r;
    end
    if (en_out) begin
      out_joint_r <= joint3_r;
      out_speed_r <= speed_nxt;
      out_lim_r   <= hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_speed_r, out_joint_r};
  assign out_tuser  = out_lim_r;

  // Nothing leaves in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  // The input stalls only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1.valid && v2_r && v3_r && out_valid_r))
    else $error("input stalled with a free stage");

  // The clamped speed never reaches the most negative code.
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_speed_r != {1'b1, {(ANG_W-1){1'b0}}}))
    else $error("speed command out of range");

endmodule
